// ===== rtl/rsa_pkg.sv =====
`timescale 1ns / 1ps

package rsa_pkg;

    // Fixed field widths of the request and response words.
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned SLOT_W     = 8;
    localparam int unsigned HINT_RANGE = 256;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned REFCNT_W   = 16;
    localparam int unsigned INUSE_W    = 9;
    localparam int unsigned FAIL_W     = 32;

    // Defaults for the top-level parameters.
    localparam int unsigned NUM_SLOTS_DEF   = 256;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RETAIN  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_FREE    = 2'd1,
        STAT_NOT_IN_USE = 2'd2,
        STAT_OVERFLOW   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_UPDATE,
        FSM_SEARCH,
        FSM_ALLOC
    } state_t;

endpackage

// ===== rtl/rsa_req_if.sv =====
`timescale 1ns / 1ps

interface rsa_req_if
    import rsa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] start_hint;

    modport source (output valid, cmd, slot, start_hint, input ready);
    modport sink   (input valid, cmd, slot, start_hint, output ready);
endinterface

// ===== rtl/rsa_rsp_if.sv =====
`timescale 1ns / 1ps

interface rsa_rsp_if
    import rsa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [REFCNT_W-1:0] ref_count;
    logic                freed;
    logic [INUSE_W-1:0]  in_use_total;
    logic [FAIL_W-1:0]   failure_total;

    modport source (output valid, status, slot_out, ref_count, freed, in_use_total,
                    failure_total, input ready);
    modport sink   (input valid, status, slot_out, ref_count, freed, in_use_total,
                    failure_total, output ready);
endinterface

// ===== rtl/rsa_ram.sv =====
`timescale 1ns / 1ps

module rsa_ram
    import rsa_pkg::*;
#(
    parameter int unsigned WIDTH = COUNT_WIDTH_DEF,
    parameter int unsigned DEPTH = NUM_SLOTS_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data is registered and holds until the next read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/rsa_finder.sv =====
`timescale 1ns / 1ps

module rsa_finder
    import rsa_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [NUM_SLOTS-1:0]         in_use,
    input  logic [$clog2(NUM_SLOTS)-1:0] start,
    output logic                         found,
    output logic [$clog2(NUM_SLOTS)-1:0] idx
);

    localparam int unsigned IDX_W = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] free_vec;
    logic [NUM_SLOTS-1:0] upper_mask;
    logic [NUM_SLOTS-1:0] pick_vec;
    logic [NUM_SLOTS-1:0] onehot_next;
    logic [NUM_SLOTS-1:0] onehot_reg;
    logic                 found_reg;

    // Free slots at or above the start win; otherwise the search wraps to
    // the lowest free slot overall. The lowest set bit is isolated with a
    // two's complement trick.
    always_comb
    begin
        free_vec = ~in_use;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            upper_mask[i] = (IDX_W'(i) >= start);
        end
        pick_vec    = (|(free_vec & upper_mask)) ? (free_vec & upper_mask) : free_vec;
        onehot_next = pick_vec & (~pick_vec + NUM_SLOTS'(1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            onehot_reg <= onehot_next;
            found_reg  <= |free_vec;
        end
    end

    // One-hot to binary encode.
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (onehot_reg[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
    end

    assign found = found_reg;

endmodule

// ===== rtl/refcount_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// Retain, release and query words pass through the update state, allocate words through
// the search and alloc states, and each waits there while the response register is occupied.
// One word is in flight at a time: a new word is taken only once the unit is back in
// idle, which the count memory read-modify-write
// and the registered free-slot search rely on. Reset clears the in-use bitmap and both totals;
// the count memory is not swept, since a slot whose bitmap bit is clear reads as zero.
module refcount_slot_allocator_unit
    import rsa_pkg::*;
#(
    parameter int unsigned NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    rsa_req_if.sink    req,
    rsa_rsp_if.source  rsp
);

    localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
    localparam int unsigned TOT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // The search start is the hint reduced modulo the slot count. The hint
    // is only eight bits wide, so a constant table does the reduction.
    logic [IDX_W-1:0] hint_mod [HINT_RANGE];

    for (genvar k = 0; k < HINT_RANGE; k++)
    begin : g_hint_mod
        localparam int unsigned HM = k % NUM_SLOTS;
        assign hint_mod[k] = HM[IDX_W-1:0];
    end

    // Control state.
    state_t               state_reg,       state_next;
    logic [NUM_SLOTS-1:0] in_use_reg,      in_use_next;
    logic [TOT_W-1:0]     in_use_cnt_reg,  in_use_cnt_next;
    logic [FAIL_W-1:0]    fail_cnt_reg,    fail_cnt_next;
    logic                 out_valid_reg,   out_valid_next;

    // Captured request word.
    cmd_t                 cmd_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 in_range_reg;
    logic [IDX_W-1:0]     start_reg;

    // Response register.
    status_t              status_reg;
    logic [SLOT_W-1:0]    slot_out_reg;
    logic [REFCNT_W-1:0]  ref_count_reg;
    logic                 freed_reg;
    logic [INUSE_W-1:0]   in_use_total_reg;
    logic [FAIL_W-1:0]    failure_total_reg;

    // Count memory and search unit signals.
    logic                   accept;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic                   find_found;
    logic [IDX_W-1:0]       find_idx;

    // Per-word results.
    logic                   commit;
    logic                   out_free;
    logic [IDX_W-1:0]       slot_idx;
    logic                   cur_used;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    status_t                res_status;
    logic [SLOT_W-1:0]      res_slot;
    logic [COUNT_WIDTH-1:0] res_count;
    logic                   res_freed;

    assign req.ready = (state_reg == FSM_IDLE);
    assign accept    = req.valid && req.ready;

    // The count memory is read at the acceptance edge, so the count is on
    // hand in the update cycle. Only one word is in flight, which keeps
    // the write-back of one word ahead of the read of the next.
    rsa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (accept),
        .rd_addr (IDX_W'(req.slot)),
        .rd_data (ram_rdata)
    );

    // The search result is registered in the search cycle and held while
    // the response register is still occupied.
    rsa_finder #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_finder (
        .clk    (clk),
        .en     (state_reg == FSM_SEARCH),
        .in_use (in_use_reg),
        .start  (start_reg),
        .found  (find_found),
        .idx    (find_idx)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd_t'(req.cmd);
            slot_reg     <= req.slot;
            in_range_reg <= (32'(req.slot) < NUM_SLOTS);
            start_reg    <= hint_mod[req.start_hint];
        end
    end

    always_comb
    begin
        slot_idx  = IDX_W'(slot_reg);
        // A slot whose bitmap bit is clear has a count of zero, whatever
        // the memory holds.
        cur_used  = in_range_reg && in_use_reg[slot_idx];
        cur_cnt   = cur_used ? ram_rdata : '0;
        out_free  = !out_valid_reg || rsp.ready;

        state_next      = state_reg;
        commit          = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = slot_idx;
        ram_wdata       = '0;
        in_use_next     = in_use_reg;
        in_use_cnt_next = in_use_cnt_reg;
        fail_cnt_next   = fail_cnt_reg;
        res_status      = STAT_OK;
        res_slot        = slot_reg;
        res_count       = '0;
        res_freed       = 1'b0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (cmd_t'(req.cmd) == CMD_ALLOC) ? FSM_SEARCH : FSM_UPDATE;
                end
            end
            FSM_UPDATE:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = FSM_IDLE;
                    if (!in_range_reg)
                    begin
                        res_status = STAT_NOT_IN_USE;
                    end
                    else
                    begin
                        case (cmd_reg)
                            CMD_QUERY:
                            begin
                                res_count = cur_cnt;
                            end
                            CMD_RETAIN:
                            begin
                                if (!cur_used)
                                begin
                                    res_status = STAT_NOT_IN_USE;
                                end
                                else if (cur_cnt == COUNT_MAX)
                                begin
                                    res_status = STAT_OVERFLOW;
                                    res_count  = COUNT_MAX;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = cur_cnt + COUNT_WIDTH'(1);
                                    res_count = cur_cnt + COUNT_WIDTH'(1);
                                end
                            end
                            CMD_RELEASE:
                            begin
                                if (!cur_used)
                                begin
                                    res_status = STAT_NOT_IN_USE;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = cur_cnt - COUNT_WIDTH'(1);
                                    res_count = cur_cnt - COUNT_WIDTH'(1);
                                    if (cur_cnt == COUNT_WIDTH'(1))
                                    begin
                                        // The last reference is gone: the slot
                                        // returns to the free pool.
                                        res_freed             = 1'b1;
                                        in_use_next[slot_idx] = 1'b0;
                                        if (in_use_cnt_reg != '0)
                                        begin
                                            in_use_cnt_next = in_use_cnt_reg - TOT_W'(1);
                                        end
                                    end
                                end
                            end
                            default:
                            begin
                                res_status = STAT_OK;
                            end
                        endcase
                    end
                end
            end
            FSM_SEARCH:
            begin
                state_next = FSM_ALLOC;
            end
            FSM_ALLOC:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = FSM_IDLE;
                    if (find_found)
                    begin
                        ram_we                = 1'b1;
                        ram_waddr             = find_idx;
                        ram_wdata             = COUNT_WIDTH'(1);
                        in_use_next[find_idx] = 1'b1;
                        in_use_cnt_next       = in_use_cnt_reg + TOT_W'(1);
                        res_slot              = SLOT_W'(find_idx);
                        res_count             = COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        // Every slot is taken: count the failure, saturating.
                        res_status = STAT_NO_FREE;
                        res_slot   = '0;
                        if (fail_cnt_reg != '1)
                        begin
                            fail_cnt_next = fail_cnt_reg + FAIL_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            in_use_reg     <= '0;
            in_use_cnt_reg <= '0;
            fail_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            in_use_cnt_reg <= in_use_cnt_next;
            fail_cnt_reg   <= fail_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // The response register carries the totals as they stand after the word.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg        <= res_status;
            slot_out_reg      <= res_slot;
            ref_count_reg     <= REFCNT_W'(res_count);
            freed_reg         <= res_freed;
            in_use_total_reg  <= INUSE_W'(in_use_cnt_next);
            failure_total_reg <= fail_cnt_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.slot_out      = slot_out_reg;
    assign rsp.ref_count     = ref_count_reg;
    assign rsp.freed         = freed_reg;
    assign rsp.in_use_total  = in_use_total_reg;
    assign rsp.failure_total = failure_total_reg;

endmodule
